// File: hdl/sha256_pkg.sv
// Shared types, constants and a rotate function for the SHA-256 hasher.
package sha256_pkg;

    localparam int LENGTH_BITS = 61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Control handed from the sequencer to the round datapath.
    typedef struct packed {
        logic       load;     // copy the hash into the working set
        logic       step;     // run one round
        logic       fold;     // add working vars into the hash
        logic       init;     // restore the initial hash
        logic [5:0] rnd;
    } t_rnd_ctrl;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: hdl/sha256_message_hasher.sv
// SHA-256 hasher top: word intake, padding, round sequencer, digest output.
// Each non-last word is stored in the block; a 16th word runs the rounds, then a fold.
// A last word runs one or two compressions plus a pad step,
// then emits eight digest beats, one per unstalled cycle.
// One shared round unit paces everything: one round per cycle, one item at a time.
// Synchronous active-low reset restores the initial hash and a zero byte count.
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_blk [16];
    logic [LENGTH_BITS-1:0] r_cnt;
    logic [5:0]  r_rnd;
    logic        r_fin;   // padding still owes a final length block
    logic        r_done;  // last compression of the message running
    logic [2:0]  r_oidx;
    t_rnd_ctrl   ctl;
    logic [31:0] hash [8];
    logic        acc;
    logic [3:0]  pos;
    logic [2:0]  vb;
    logic        spill;   // padding leaves no room for the length in this block
    logic [LENGTH_BITS-1:0] cnt_add;
    logic [63:0] bits;
    logic [31:0] mask, padw;

    assign acc = i_valid && !o_stall;
    assign pos = r_cnt[5:2];
    assign vb  = (!i_last_item || i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
    assign spill = (vb == 3'd4) ? (pos >= 4'd13) : (pos >= 4'd14);
    assign cnt_add = r_cnt + LENGTH_BITS'(vb);
    assign bits = 64'({r_cnt, 3'b000});

    always_comb begin
        unique case (vb)
            3'd0:    mask = 32'h0;
            3'd1:    mask = 32'hff000000;
            3'd2:    mask = 32'hffff0000;
            3'd3:    mask = 32'hffffff00;
            default: mask = 32'hffffffff;
        endcase
        padw = (i_data_word & mask) | (32'h80000000 >> {vb, 3'b000});
    end

    sha256_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctl),
        .i_block (r_blk),
        .o_hash  (hash)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc) begin
                if (!i_last_item) n_state = (pos == 4'd15) ? ST_ROUND : ST_IDLE;
                else if (spill) n_state = ST_ROUND;
                else n_state = ST_PAD;
            end
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_FOLD;
            ST_FOLD:  n_state = r_done ? ST_EMIT : (r_fin ? ST_PAD : ST_IDLE);
            ST_PAD:   n_state = ST_ROUND;
            ST_EMIT:  if (!i_stall && r_oidx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        ctl.rnd = r_rnd;
        o_stall = (r_state != ST_IDLE);
        o_valid = (r_state == ST_EMIT);
        unique case (r_state)
            ST_ROUND: ctl.step = 1'b1;
            ST_FOLD:  ctl.fold = 1'b1;
            ST_EMIT:  ctl.init = !i_stall && r_oidx == 3'd7;
            default:  ctl.load = 1'b0;
        endcase
        ctl.load = (n_state == ST_ROUND) && (r_state != ST_ROUND);
    end

    assign o_digest_word = hash[r_oidx];
    assign o_digest_last = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_done  <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: if (acc) begin
                    r_cnt <= cnt_add;
                    if (!i_last_item) begin
                        r_blk[pos] <= i_data_word;
                    end else if (vb == 3'd4 && pos == 4'd15) begin
                        // full word closes the block; pad goes in a new block
                        r_blk[pos] <= i_data_word;
                        r_fin <= 1'b1;
                        r_done <= 1'b0;
                    end else begin
                        r_blk[pos] <= (vb == 3'd4) ? i_data_word : padw;
                        if (vb == 3'd4) r_blk[pos + 4'd1] <= 32'h80000000;
                        for (int i = 0; i < 16; i++)
                            if (4'(i) > pos + ((vb == 3'd4) ? 4'd1 : 4'd0))
                                r_blk[i] <= 32'h0;
                        // length fits when padding ends at or before word 13
                        r_fin <= 1'b1;
                        r_done <= !spill;
                    end
                end
                ST_ROUND: r_rnd <= r_rnd + 6'd1;
                ST_FOLD:  if (r_done) r_fin <= 1'b0;
                ST_PAD: begin
                    // writes the length; for an extra length block the marker byte lands in
                    // word 0 only when the data itself filled the previous block
                    if (!r_done) begin
                        r_blk[0] <= (pos == 4'd0) ? 32'h80000000 : 32'h0;
                        for (int i = 1; i < 14; i++) r_blk[i] <= 32'h0;
                        r_done <= 1'b1;
                    end
                    r_blk[14] <= bits[63:32];
                    r_blk[15] <= bits[31:0];
                end
                ST_EMIT: if (!i_stall) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_cnt <= '0;
                        r_fin <= 1'b0;
                        r_done <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> o_stall) else $error("ready during rounds");
    a_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD && r_done) |=> o_valid && r_oidx == 3'd0)
        else $error("digest not started");
    a_rndz : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> r_rnd == 6'd0) else $error("round count stale");
endmodule

// File: hdl/sha256_round.sv
// One shared round unit with working variables, schedule window and hash state.
module sha256_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_rnd_ctrl i_ctrl,
    input  logic [31:0]           i_block [16],
    output logic [31:0]           o_hash [8]
);
    import sha256_pkg::*;

    logic [31:0] r_hash [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [31:0] w_new, w_cur, t1, t2, m2, m7, m15, s0, s1;
    logic [3:0]  slot;
    logic [31:0] a, b, c, e, f, g;

    assign slot = i_ctrl.rnd[3:0];
    assign a = r_v[0];
    assign b = r_v[1];
    assign c = r_v[2];
    assign e = r_v[4];
    assign f = r_v[5];
    assign g = r_v[6];

    always_comb begin
        m2    = r_w[slot - 4'd2];
        m7    = r_w[slot - 4'd7];
        m15   = r_w[slot - 4'd15];
        s1    = rotr(m2, 17) ^ rotr(m2, 19) ^ (m2 >> 10);
        s0    = rotr(m15, 7) ^ rotr(m15, 18) ^ (m15 >> 3);
        w_new = s1 + m7 + s0 + r_w[slot];
        // first sixteen rounds take the block words directly and fill the window
        w_cur = (i_ctrl.rnd[5:4] == 2'd0) ? i_block[slot] : w_new;
        t1    = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & f) ^ (~e & g)) + K_TAB[i_ctrl.rnd] + w_cur;
        t2    = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & b) ^ (a & c) ^ (b & c));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.init) begin
            r_hash <= H_INIT;
        end else if (i_ctrl.fold) begin
            for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_v[i];
        end
        if (i_ctrl.load) begin
            r_v <= r_hash;
        end else if (i_ctrl.step) begin
            r_w[slot] <= w_cur;
            r_v[7] <= g;
            r_v[6] <= f;
            r_v[5] <= e;
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= c;
            r_v[2] <= b;
            r_v[1] <= a;
            r_v[0] <= t1 + t2;
        end
    end

    assign o_hash = r_hash;

    a_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.load && i_ctrl.step)) else $error("load with step");
    a_fold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.fold && i_ctrl.init)) else $error("fold with init");
    a_rnd0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load |-> i_ctrl.rnd == 6'd0) else $error("load mid block");
endmodule

// File: sim/tb_sha256_message_hasher.sv
// Testbench for the SHA-256 message hasher: queued word driver, digest predictor and monitor.
module tb_sha256_message_hasher;
    import sha256_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } t_word;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_digest;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_data_word = '0;
    logic [2:0]  i_valid_bytes = '0;
    logic        i_last_item = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic        o_digest_last;

    sha256_message_hasher u_top (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [31:0] hv [8];
    logic [31:0] blk [16];
    logic [LENGTH_BITS-1:0] nbytes_seen;

    t_word   word_q [$];
    t_digest digest_q [$];
    int      errors = 0;
    bit      feeding_done = 0;
    bit      in_taken = 0;
    int      idle_cycles = 0;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t1, t2, m2, m15;
        int r, s;
        w = blk;
        v = hv;
        for (r = 0; r < 64; r++) begin
            s = r & 15;
            if (r >= 16) begin
                m2 = w[(r - 2) & 15];
                m15 = w[(r - 15) & 15];
                w[s] = (ror(m2, 17) ^ ror(m2, 19) ^ (m2 >> 10)) + w[(r - 7) & 15]
                     + (ror(m15, 7) ^ ror(m15, 18) ^ (m15 >> 3)) + w[s];
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[s];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++) hv[r] = hv[r] + v[r];
    endtask

    task automatic clear_hash();
        hv = H_INIT;
        nbytes_seen = '0;
    endtask

    task automatic predict_word(t_word it);
        int pos, nb, i;
        logic [31:0] wd;
        logic [63:0] bits;
        pos = int'(nbytes_seen[5:2]);
        if (!it.last) begin
            blk[pos] = it.data;
            nbytes_seen = nbytes_seen + 4;
            if (pos == 15) compress_blk();
            return;
        end
        nb = (it.nbytes > 4) ? 4 : int'(it.nbytes);
        nbytes_seen = nbytes_seen + nb;
        if (nb == 4) begin
            blk[pos] = it.data;
            pos++;
            if (pos == 16) begin
                compress_blk();
                pos = 0;
            end
            blk[pos] = 32'h8000_0000;
        end else begin
            wd = (nb > 0) ? (it.data & (32'hFFFF_FFFF << (32 - 8 * nb))) : 32'h0;
            wd |= 32'h80 << (24 - 8 * nb);
            blk[pos] = wd;
        end
        pos++;
        if (pos > 14) begin
            for (i = pos; i < 16; i++) blk[i] = '0;
            compress_blk();
            pos = 0;
        end
        for (i = pos; i < 14; i++) blk[i] = '0;
        bits = 64'(nbytes_seen) << 3;
        blk[14] = bits[63:32];
        blk[15] = bits[31:0];
        compress_blk();
        for (i = 0; i < 8; i++) digest_q.push_back('{word: hv[i], last: (i == 7)});
        clear_hash();
    endtask

    task automatic add_msg(int len, bit odd_nb);
        t_word it;
        int k;
        for (k = 0; k < len; k++) begin
            it.data = $urandom;
            it.nbytes = odd_nb ? 3'($urandom_range(0, 7)) : 3'd4;
            it.last = 1'b0;
            word_q.push_back(it);
        end
        it.data = $urandom;
        it.nbytes = 3'($urandom_range(0, 7));
        it.last = 1'b1;
        word_q.push_back(it);
    endtask

    // Sender: bursts with random gaps; payload held until accepted.
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (in_taken) begin
                void'(word_q.pop_front());
                in_taken = 1'b0;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (word_q.size() > 0) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                end
                burst_left--;
                if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ?
                                                $urandom_range(1, 80) : 0;
                i_valid <= 1'b1;
                i_data_word <= word_q[0].data;
                i_valid_bytes <= word_q[0].nbytes;
                i_last_item <= word_q[0].last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: phases of free running, light and heavy stalling.
    int stall_mode = 0, stall_phase = 0;
    always @(negedge i_clk) begin
        if (stall_phase == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_phase = $urandom_range(10, 300);
        end
        stall_phase--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_word({i_data_word, i_valid_bytes, i_last_item});
                in_taken = 1'b1;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
            if (o_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest beat %h", $time, o_digest_word);
                    errors <= errors + 1;
                end else begin
                    if (o_digest_word !== digest_q[0].word ||
                        o_digest_last !== digest_q[0].last) begin
                        $display("%0t: digest mismatch exp %h/%b got %h/%b", $time,
                                 digest_q[0].word, digest_q[0].last,
                                 o_digest_word, o_digest_last);
                        errors <= errors + 1;
                    end
                    void'(digest_q.pop_front());
                end
            end
        end
    end

    initial begin
        t_word it;
        int n, k;
        clear_hash();
        for (k = 0; k < 16; k++) blk[k] = '0;
        // Directed: empty message, known vector "abc", padding boundaries.
        word_q.push_back('{data: 32'h0, nbytes: 3'd0, last: 1'b1});
        word_q.push_back('{data: 32'h6162_63FF, nbytes: 3'd3, last: 1'b1});
        add_msg(13, 0);   // last word lands on slot 13, length spills when it is a full word
        add_msg(15, 1);   // last word lands on slot 15 and fills the block when full, odd counts on body words
        add_msg(0, 0);
        word_q.push_back('{data: 32'hFFFF_FFFF, nbytes: 3'd7, last: 1'b1});
        word_q.push_back('{data: 32'hFFFF_FFFF, nbytes: 3'd4, last: 1'b1});
        word_q.push_back('{data: 32'hFFFF_FFFF, nbytes: 3'd1, last: 1'b1});
        word_q.push_back('{data: 32'hFFFF_FFFF, nbytes: 3'd2, last: 1'b1});
        word_q.push_back('{data: 32'h0000_0000, nbytes: 3'd5, last: 1'b1});
        // Random messages, mostly short, a few crossing block boundaries.
        n = 0;
        while (n < 80) begin
            k = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 34) : $urandom_range(0, 8);
            add_msg(k, $urandom_range(0, 3) == 0);
            n += k + 1;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        wait (word_q.size() == 0 && !i_valid);
        wait (digest_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
